>>> src/assert_macros.svh
// Assertion macros used by the RTL of the PID controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NPID_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("npid: assertion failed");
`define NPID_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("npid: forbidden condition seen");
`else
`define NPID_ASSERT(label, prop)
`define NPID_ASSERT_NEVER(label, expr)
`endif
`endif

>>> src/npid_pkg.sv
// Types, constants and sequencer states of the normalized PID controller.
package npid_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int DT_W      = 31;
  localparam int SUM_W     = 48;
  localparam int ACC_W     = 88;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_MIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd7;

  // Plus one in Q2.30 and in the Q.46 scale of the gain products.
  localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;
  localparam logic signed [ACC_W-1:0] LIM_POS = {{(ACC_W-47){1'b0}}, 1'b1, 46'b0};
  localparam logic signed [ACC_W-1:0] LIM_NEG = -LIM_POS;

  typedef struct packed {
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] measured;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     limited;
    logic                     fault;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_NSET, S_NDIV, S_ERR, S_IMUL, S_IADD,
    S_DDIV, S_PID, S_LIM, S_DMUL, S_DABS, S_OUT
  } state_t;

endpackage

>>> src/normalized_pid_controller.sv
// Normalized PID controller built around one shared divider and one shared MAC.
//
//   port group  | direction | handshake          | word
//   in_*        | input     | in_valid/in_stall  | in_t: target, measured
//   out_*       | output    | out_valid/out_stall| out_t: drive, limited, fault
//   cfg_*       | input     | cfg_write          | cfg_index, cfg_data
//
// A word passes normalization, integral, derivative, PID sum and drive mapping
// before the output register; it skips them when the span or time step is zero.
// Two 32-step and one 49-step restoring divisions, one quotient bit per cycle,
// and the 34x17 MAC, which takes each product in 16-bit chunks, do the work.
// in_stall is high while a word is in work or its result waits on out_stall.
// Reset is synchronous; it restores register defaults and clears the integral.
`include "assert_macros.svh"
module normalized_pid_controller import npid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  state_t state, state_next;

  logic        [DT_W-1:0]   time_step;
  logic signed [DATA_W-1:0] process_min, process_max, drive_min, drive_max;
  logic signed [DATA_W-1:0] gain_p, gain_i, gain_d;

  logic signed [SUM_W-1:0]  error_sum;
  logic signed [31:0]       last_error;

  logic signed [DATA_W-1:0] tgt, meas, sp_n, err;
  logic                     sel, fault_r, lim_r, neg_r, dneg;
  logic [5:0]               cnt;
  logic [1:0]               k, term;
  logic [33:0]              rem;
  logic [32:0]              den;
  logic [48:0]              quo, dvd;
  logic signed [49:0]       deriv;
  logic signed [33:0]       op_a;
  logic signed [63:0]       op_b;
  logic signed [ACC_W-1:0]  acc;

  // Normalization setup.
  logic signed [DATA_W-1:0] x_sel, x_hi, x_cl;
  logic signed [32:0]       num_w, span;
  logic [32:0]              den_w;
  always_comb begin
    x_sel = sel ? meas : tgt;
    x_hi  = (x_sel > process_max) ? process_max : x_sel;
    x_cl  = (x_hi < process_min) ? process_min : x_hi;
    num_w = 33'(x_cl) - 33'(process_min);
    span  = 33'(process_max) - 33'(process_min);
    den_w = span[32] ? 33'(-span) : 33'(span);
  end

  // Shared divider step.
  logic [33:0] rin, dop, rsub, rdiff;
  logic        ge;
  always_comb begin
    if (state == S_DDIV) begin
      rin = {rem[32:0], dvd[48]};
      dop = {3'b0, time_step};
    end else begin
      rin = rem;
      dop = {1'b0, den};
    end
    ge    = rin >= dop;
    rsub  = rin - dop;
    rdiff = ge ? rsub : rin;
  end

  // The last quotient bit is still in flight on the final step.
  logic signed [32:0] nq;
  assign nq = $signed({1'b0, quo[30:0], ge}) - ONE_Q30;

  // Shared multiply-accumulate step.
  logic signed [16:0]      chunk;
  logic signed [50:0]      prod;
  logic signed [ACC_W-1:0] prod_ext, acc_add;
  always_comb begin
    unique case (k)
      2'd0: chunk = $signed({1'b0, op_b[15:0]});
      2'd1: chunk = $signed({1'b0, op_b[31:16]});
      2'd2: chunk = $signed({1'b0, op_b[47:32]});
      default: chunk = $signed({op_b[63], op_b[63:48]});
    endcase
    prod     = op_a * chunk;
    prod_ext = ACC_W'(prod);
    acc_add  = acc + (prod_ext <<< {k, 4'b0});
  end

  // Error, integral and derivative. The measured value is normalized into
  // the same register as its input.
  logic signed [32:0]      e33, diff33;
  logic signed [31:0]      err_w;
  logic signed [ACC_W-1:0] ish;
  logic signed [49:0]      es_sum;
  logic signed [SUM_W-1:0] es_sat;
  logic [32:0]             absdiff;
  always_comb begin
    e33     = 33'(sp_n) - 33'(meas);
    err_w   = (!e33[32] && e33[31]) ? 32'sh7fffffff : e33[31:0];
    ish     = acc >>> FRAC_BITS;
    es_sum  = 50'(error_sum) + ish[49:0];
    if (es_sum[49:47] == 3'b000 || es_sum[49:47] == 3'b111) begin
      es_sat = es_sum[SUM_W-1:0];
    end else if (es_sum[49]) begin
      es_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      es_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end
    diff33  = 33'(err) - 33'(last_error);
    absdiff = diff33[32] ? 33'(-diff33) : 33'(diff33);
  end

  // Clamp of the weighted sum and drive mapping.
  logic               pos_lim, neg_lim;
  logic signed [31:0] v30;
  logic signed [32:0] v1, ospan;
  logic [31:0]        q;
  logic signed [31:0] drive_w;
  always_comb begin
    pos_lim = acc > LIM_POS;
    neg_lim = acc < LIM_NEG;
    if (pos_lim) begin
      v30 = 32'sd1073741824;
    end else if (neg_lim) begin
      v30 = -32'sd1073741824;
    end else begin
      v30 = acc[47:16];
    end
    v1      = 33'(v30) + ONE_Q30;
    ospan   = 33'(drive_max) - 33'(drive_min);
    q       = acc[62:31];
    drive_w = neg_r ? drive_min - $signed(q) : drive_min + $signed(q);
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (span == '0 || time_step == '0) ? S_OUT : S_NSET;
        end
      end
      S_NSET: state_next = S_NDIV;
      S_NDIV: begin
        if (cnt == 6'd31) begin
          state_next = sel ? S_ERR : S_NSET;
        end
      end
      S_ERR:  state_next = S_IMUL;
      S_IMUL: begin
        if (k == 2'd3) begin
          state_next = S_IADD;
        end
      end
      S_IADD: state_next = S_DDIV;
      S_DDIV: begin
        if (cnt == 6'd48) begin
          state_next = S_PID;
        end
      end
      S_PID: begin
        if (k == 2'd3 && term == 2'd2) begin
          state_next = S_LIM;
        end
      end
      S_LIM:  state_next = S_DMUL;
      S_DMUL: begin
        if (k == 2'd3) begin
          state_next = S_DABS;
        end
      end
      S_DABS: state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= 31'd65536;
      process_min <= '0;
      process_max <= 32'sd65536;
      drive_min   <= '0;
      drive_max   <= 32'sd65536;
      gain_p      <= 32'sd65536;
      gain_i      <= '0;
      gain_d      <= '0;
      error_sum   <= '0;
      last_error  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_TIME_STEP:   time_step   <= cfg_data[DT_W-1:0];
          REG_PROCESS_MIN: process_min <= cfg_data;
          REG_PROCESS_MAX: process_max <= cfg_data;
          REG_DRIVE_MIN:   drive_min   <= cfg_data;
          REG_DRIVE_MAX:   drive_max   <= cfg_data;
          REG_GAIN_P:      gain_p      <= cfg_data;
          REG_GAIN_I:      gain_i      <= cfg_data;
          REG_GAIN_D:      gain_d      <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_IADD) begin
        error_sum  <= es_sat;
        last_error <= err;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        tgt     <= in_data.target;
        meas    <= in_data.measured;
        sel     <= 1'b0;
        fault_r <= (span == '0 || time_step == '0);
        lim_r   <= 1'b0;
      end
      S_NSET: begin
        rem <= {1'b0, num_w};
        den <= den_w;
        quo <= '0;
        cnt <= '0;
      end
      S_NDIV: begin
        rem <= {rdiff[32:0], 1'b0};
        quo <= {quo[47:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          if (sel) begin
            meas <= nq[31:0];
          end else begin
            sp_n <= nq[31:0];
            sel  <= 1'b1;
          end
        end
      end
      S_ERR: begin
        err  <= err_w;
        op_a <= 34'(err_w);
        op_b <= {33'b0, time_step};
        acc  <= '0;
        k    <= '0;
      end
      S_IMUL: begin
        acc <= acc_add;
        k   <= k + 2'd1;
      end
      S_IADD: begin
        dvd  <= {absdiff, 16'b0};
        dneg <= diff33[32];
        rem  <= '0;
        quo  <= '0;
        cnt  <= '0;
      end
      S_DDIV: begin
        rem <= rdiff;
        quo <= {quo[47:0], ge};
        dvd <= {dvd[47:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd48) begin
          op_a <= 34'(gain_p);
          op_b <= 64'(err);
          acc  <= '0;
          k    <= '0;
          term <= '0;
          deriv <= dneg ? -$signed({1'b0, quo[47:0], ge})
                        : $signed({1'b0, quo[47:0], ge});
        end
      end
      S_PID: begin
        acc <= acc_add;
        k   <= k + 2'd1;
        if (k == 2'd3) begin
          term <= term + 2'd1;
          if (term == 2'd0) begin
            op_a <= 34'(gain_i);
            op_b <= 64'(error_sum);
          end else begin
            op_a <= 34'(gain_d);
            op_b <= 64'(deriv);
          end
        end
      end
      S_LIM: begin
        lim_r <= pos_lim || neg_lim;
        op_a  <= 34'(v1);
        op_b  <= 64'(ospan);
        acc   <= '0;
        k     <= '0;
      end
      S_DMUL: begin
        acc <= acc_add;
        k   <= k + 2'd1;
      end
      S_DABS: begin
        neg_r <= acc[ACC_W-1];
        acc   <= acc[ACC_W-1] ? -acc : acc;
      end
      S_OUT: begin
        if (out_free) begin
          out_data.drive   <= fault_r ? '0 : drive_w;
          out_data.limited <= fault_r ? 1'b0 : lim_r;
          out_data.fault   <= fault_r;
        end
      end
      default: ;
    endcase
  end

  `NPID_ASSERT(a_fault_word, out_valid && out_data.fault |-> out_data.drive == '0 && !out_data.limited)
  `NPID_ASSERT(a_sum_only_in_update, state != S_IADD |=> $stable(error_sum))
  `NPID_ASSERT(a_out_from_sequencer, $rose(out_valid) |-> $past(state) == S_OUT)
  `NPID_ASSERT_NEVER(a_norm_count, state == S_NDIV && cnt > 6'd31)

endmodule
